### hdl/ssba_pkg.sv
// Shared types, widths and codes for the swap slot bitmap allocator.
// No dependencies; every other file of the block imports this package.

package ssba_pkg;

  // Field widths of the request, response and configuration register
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 11;

  // Bitmap memory organization: one word holds 32 slot bits
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Default capacity of the bitmap in slots
  localparam int MAX_SLOTS_DEF = 1024;

  // Configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  // Request command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RESP
  } ssba_state_t;

  // Result of examining one bitmap word
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
    logic             last;
  } ssba_scan_t;

endpackage

### hdl/ssba_if.sv
// Request and response channel interfaces of the swap slot allocator.
// Depends on ssba_pkg for the field widths.

interface ssba_req_if import ssba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output cmd, output slot, input ready);
  modport sink (input valid, input cmd, input slot, output ready);
endinterface

interface ssba_rsp_if import ssba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_res;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot_res, output status, input ready);
  modport sink (input valid, input slot_res, input status, output ready);
endinterface

### hdl/ssba_bitmap_ram.sv
// Used/free bitmap store: one write port and one read port, registered read data.
// Depends on ssba_pkg for the word width.

module ssba_bitmap_ram import ssba_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/ssba_word_scan.sv
// Find the lowest free slot of one bitmap word below the usable limit.
// Depends on ssba_pkg for the word width and the scan result struct.

module ssba_word_scan import ssba_pkg::*; #(
  parameter int CW = CNT_W,
  parameter int AW = 5
) (
  input  logic [WORD_W-1:0] data,
  input  logic [AW-1:0]     word,
  input  logic [CW-1:0]     limit,
  output ssba_scan_t        res
);

  logic [CW:0]       base;
  logic [CW:0]       remain;
  logic [WORD_W-1:0] free_bits;
  logic [BIT_W-1:0]  idx;

  // Slots left from the start of this word up to the limit
  assign base   = (CW+1)'({word, BIT_W'(0)});
  assign remain = {1'b0, limit} - base;

  // Mark free bits that lie below the limit
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_bits[b] = !data[b] && (remain > (CW+1)'(b));
    end
  end

  // Priority encode, lowest index wins
  always_comb begin
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        idx = BIT_W'(b);
      end
    end
  end

  assign res.hit     = |free_bits;
  assign res.bit_idx = idx;
  assign res.last    = (remain <= (CW+1)'(WORD_W));

endmodule

### hdl/swap_slot_bitmap_allocator.sv
// Swap slot bitmap allocator: top level with sequencer and configuration port.
// Depends on ssba_pkg, ssba_if, ssba_bitmap_ram and ssba_word_scan.
//
// Usage: requests arrive on req (cmd, slot); each gives exactly one response
// on rsp (slot_res, status). cmd allocate returns the lowest free slot below
// slot_count, or status full; cmd free releases slot, or answers status bad
// when the slot is out of range or not in use. slot_count is the single APB
// register at every address; write it only while the block is idle.
// Flow: a free reads its word on acceptance, then checks and writes it back in
// S_FREE; an allocate scans in S_SCAN from word 0 up to the hit or the limit.
// Both then load the output register in S_RESP. The scan reads one 32-bit word
// per cycle from the bitmap memory's single read port.
// One request is in flight at a time; req.ready is high again once the result
// sits in the output register.
// Reset: a clearing pass writes every bitmap word to zero, one per cycle
// (MAX_SLOTS/32 rounded up words, 32 by default); req.ready stays low until
// it ends. The block does not check that slot_count writes come while idle.
// Stall: the response register holds while rsp.ready is low; one more request
// is accepted and completed, then the block waits for the register to drain.

module swap_slot_bitmap_allocator import ssba_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  ssba_req_if.sink           req,
  ssba_rsp_if.source         rsp
);

  localparam int DEPTH = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(MAX_SLOTS + 1);
  localparam int CW    = (LW > CNT_W) ? LW : CNT_W;

  ssba_state_t         state, state_next;
  logic [CNT_W-1:0]    slot_count;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [AW-1:0]       cur_word, cur_word_next;
  logic [AW-1:0]       free_word, free_word_next;
  logic [BIT_W-1:0]    free_bit, free_bit_next;
  logic                free_ok, free_ok_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                out_valid, out_valid_next;
  logic [SLOT_W-1:0]   out_slot, out_slot_next;
  logic [STATUS_W-1:0] out_status, out_status_next;

  logic [CW-1:0]       count_ext;
  logic [CW-1:0]       limit;
  logic [CW-1:0]       slot_ext;
  logic [AW-1:0]       slot_word;
  logic [AW+BIT_W-1:0] alloc_idx;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [WORD_W-1:0]   rd_data;
  ssba_scan_t          scan;

  // Configuration register, single entry, every write lands in slot_count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
    end else if (psel && penable && pwrite) begin
      slot_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = PDATA_W'(slot_count);
  assign pready = 1'b1;

  // Clamp the slot count to the bitmap capacity
  assign count_ext = CW'(slot_count);
  assign limit     = (count_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : count_ext;

  // Word and bit of the slot named by a free request
  assign slot_ext  = CW'(req.slot);
  assign slot_word = slot_ext[AW+BIT_W-1:BIT_W];
  assign alloc_idx = {cur_word, scan.bit_idx};

  ssba_bitmap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssba_word_scan #(
    .CW (CW),
    .AW (AW)
  ) u_scan (
    .data  (rd_data),
    .word  (cur_word),
    .limit (limit),
    .res   (scan)
  );

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_word   <= cur_word_next;
    free_word  <= free_word_next;
    free_bit   <= free_bit_next;
    free_ok    <= free_ok_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    out_slot   <= out_slot_next;
    out_status <= out_status_next;
  end

  // Sequencer: clear, accept, scan or check, then hand the result over.
  // The write-back of a request lands before the next request reads, so no
  // forwarding is needed.
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    cur_word_next   = cur_word;
    free_word_next  = free_word;
    free_bit_next   = free_bit;
    free_ok_next    = free_ok;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    out_slot_next   = out_slot;
    out_status_next = out_status;
    out_valid_next  = out_valid;
    req.ready       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = free_word;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    // Drop the response once taken
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          rd_en = 1'b1;
          if (req.cmd == CMD_FREE) begin
            rd_addr        = slot_word;
            free_word_next = slot_word;
            free_bit_next  = slot_ext[BIT_W-1:0];
            free_ok_next   = (slot_ext < limit);
            state_next     = S_FREE;
          end else begin
            rd_addr       = '0;
            cur_word_next = '0;
            if (limit == '0) begin
              res_slot_next   = '0;
              res_status_next = ST_FULL;
              state_next      = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan.hit) begin
          // Mark the slot used and report it
          wr_en           = 1'b1;
          wr_addr         = cur_word;
          wr_data         = rd_data | (WORD_W'(1) << scan.bit_idx);
          res_slot_next   = SLOT_W'(alloc_idx);
          res_status_next = ST_OK;
          state_next      = S_RESP;
        end else if (scan.last) begin
          res_slot_next   = '0;
          res_status_next = ST_FULL;
          state_next      = S_RESP;
        end else begin
          // Advance to the next word
          rd_en         = 1'b1;
          rd_addr       = cur_word + AW'(1);
          cur_word_next = cur_word + AW'(1);
        end
      end
      S_FREE: begin
        res_slot_next = '0;
        if (free_ok && rd_data[free_bit]) begin
          wr_en           = 1'b1;
          wr_addr         = free_word;
          wr_data         = rd_data & ~(WORD_W'(1) << free_bit);
          res_status_next = ST_OK;
        end else begin
          res_status_next = ST_BAD;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        // Hold until the output register is free
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_slot_next   = res_slot;
          out_status_next = res_status;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid    = out_valid;
  assign rsp.slot_res = out_slot;
  assign rsp.status   = out_status;

endmodule

### hdl/ssba_checker.sv
// Port-level checks for the swap slot bitmap allocator, bound to the top level.
// Depends on ssba_pkg for the status codes and widths.

module ssba_checker import ssba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [SLOT_W-1:0]   rsp_slot_res,
  input logic [STATUS_W-1:0] rsp_status
);

  // The clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request port ready right after reset");

  // One request at a time: no second request in the cycle after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request port ready directly after an acceptance");

  // A response with a status other than OK carries slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_OK) |-> (rsp_slot_res == '0))
    else $error("non-zero slot on a failed response");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_slot_res) && $stable(rsp_status)))
    else $error("stalled response changed");

endmodule

bind swap_slot_bitmap_allocator ssba_checker u_ssba_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_slot_res (rsp.slot_res),
  .rsp_status   (rsp.status)
);
